// ----- sv/msfl_pkg.sv -----
// msfl_pkg: shared types, codes and constants of the manchester sensor frame link
// no dependencies; imported by every module of the block
package msfl_pkg;

  localparam int unsigned PreambleBitsDef = 8;

  localparam int unsigned BitCntW   = 6;
  localparam int unsigned WaitW     = 10;
  localparam int unsigned TimeoutW  = 10;
  localparam int unsigned PollW     = 4;
  localparam int unsigned DelayW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned OpW       = 2;
  localparam int unsigned RefW      = 4;
  localparam int unsigned AgcW      = 2;
  localparam int unsigned LedW      = 10;
  localparam int unsigned FrameW    = 12;
  localparam int unsigned RespKeepW = 35;
  localparam int unsigned HoldW     = AgcW + LedW + RefW;

  localparam int unsigned WrPayloadBits = 12;
  localparam int unsigned RdPayloadBits = 4;
  localparam int unsigned RespBits      = 37;

  localparam logic [3:0]        WrCommand = 4'hC;
  localparam logic [1:0]        WrBank    = 2'h2;
  localparam logic [FrameW-1:0] RdFrame   = 12'h100;

  localparam logic [TimeoutW-1:0] AckTimeoutRst = 10'd100;
  localparam logic [PollW-1:0]    AckPollRst    = 4'd2;
  localparam logic [DelayW-1:0]   RespDelayRst  = 8'd5;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } msfl_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_RESP_ERR = 2'd2
  } msfl_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACK_TIMEOUT = 2'd0,
    REG_ACK_POLL    = 2'd1,
    REG_RESP_DELAY  = 2'd2
  } msfl_reg_e;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SENDW = 6'b000010,
    PH_SENDR = 6'b000100,
    PH_ACK   = 6'b001000,
    PH_DELAY = 6'b010000,
    PH_RECV  = 6'b100000
  } msfl_phase_e;

  typedef struct packed {
    logic [TimeoutW-1:0] ack_timeout;
    logic [PollW-1:0]    ack_poll;
    logic [DelayW-1:0]   resp_delay;
  } msfl_cfg_t;

  typedef struct packed {
    msfl_op_e        op;
    logic [RefW-1:0] ref_level;
    logic            polarity;
    logic            out_line;
  } msfl_item_t;

  typedef struct packed {
    logic            cal_line;
    logic            busy;
    logic            done;
    msfl_status_e    status;
    logic [AgcW-1:0] agc_gain;
    logic [LedW-1:0] led_current;
    logic [RefW-1:0] ref_readback;
  } msfl_res_t;

endpackage

// ----- sv/msfl_cfg.sv -----
// msfl_cfg: configuration registers written through the plain write port
// depends on msfl_pkg
module msfl_cfg import msfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  index_i,
  input  logic [CfgDataW-1:0] data_i,
  output msfl_cfg_t           cfg_o
);

  msfl_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        REG_ACK_TIMEOUT: cfg_d.ack_timeout = data_i[TimeoutW-1:0];
        REG_ACK_POLL:    cfg_d.ack_poll    = data_i[PollW-1:0];
        REG_RESP_DELAY:  cfg_d.resp_delay  = data_i[DelayW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout <= AckTimeoutRst;
      cfg_q.ack_poll    <= AckPollRst;
      cfg_q.resp_delay  <= RespDelayRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/msfl_engine.sv -----
// msfl_engine: per-tick link state machine, frame serializer, ack poll and response capture
// depends on msfl_pkg; one step per beat taken from the input register
module msfl_engine import msfl_pkg::*; #(
  parameter int unsigned PREAMBLE_BITS = PreambleBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  msfl_item_t item_i,
  input  msfl_cfg_t  cfg_i,
  output msfl_res_t  res_o
);

  localparam logic [BitCntW-1:0] PreCnt  = BitCntW'(PREAMBLE_BITS);
  localparam logic [BitCntW-1:0] WrEnd   = BitCntW'(PREAMBLE_BITS + WrPayloadBits);
  localparam logic [BitCntW-1:0] RdEnd   = BitCntW'(PREAMBLE_BITS + RdPayloadBits);
  localparam logic [BitCntW-1:0] RespEnd = BitCntW'(RespBits);

  msfl_phase_e          phase_q, phase_d, cur_phase;
  logic [FrameW-1:0]    frame_q, frame_d, cur_frame;
  logic [BitCntW-1:0]   bit_q, bit_d, cur_bit, bit_inc, end_cnt;
  logic                 half_q, half_d, cur_half;
  logic [WaitW-1:0]     wait_q, wait_d, wait_inc;
  logic [PollW-1:0]     poll_cnt_q, poll_cnt_d, poll_inc;
  logic                 ack_ref_q, ack_ref_d;
  logic [RespKeepW-1:0] resp_q, resp_d;
  logic [HoldW-1:0]     hold_q, hold_d;
  logic                 start, bit_v, poll_one, cal;
  logic                 done;
  msfl_status_e         status;

  always_comb begin
    start = (phase_q == PH_IDLE) && (item_i.op == OP_WRITE || item_i.op == OP_READ);
    cur_phase = phase_q;
    cur_frame = frame_q;
    cur_bit   = bit_q;
    cur_half  = half_q;
    if (start) begin
      cur_bit  = '0;
      cur_half = 1'b0;
      if (item_i.op == OP_WRITE) begin
        cur_phase = PH_SENDW;
        cur_frame = {WrCommand, WrBank, item_i.ref_level, 1'b0, item_i.polarity};
      end else begin
        cur_phase = PH_SENDR;
        cur_frame = RdFrame;
      end
    end

    phase_d    = cur_phase;
    frame_d    = cur_frame;
    bit_d      = cur_bit;
    half_d     = cur_half;
    wait_d     = wait_q;
    poll_cnt_d = poll_cnt_q;
    ack_ref_d  = ack_ref_q;
    resp_d     = resp_q;
    hold_d     = hold_q;
    cal        = 1'b0;
    done       = 1'b0;
    status     = ST_OK;

    bit_inc  = cur_bit + BitCntW'(1);
    wait_inc = wait_q + WaitW'(1);
    poll_inc = poll_cnt_q + PollW'(1);
    poll_one = (cfg_i.ack_poll <= PollW'(1));
    bit_v    = (cur_bit < PreCnt) ? 1'b1 : cur_frame[FrameW-1];
    end_cnt  = (cur_phase == PH_SENDW) ? WrEnd : RdEnd;

    unique case (cur_phase) inside
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_SENDW, PH_SENDR: begin
        cal = cur_half ? bit_v : ~bit_v;
        if (!cur_half) begin
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (cur_bit >= PreCnt) begin
            frame_d = {cur_frame[FrameW-2:0], 1'b0};
          end
          bit_d = bit_inc;
          if (bit_inc >= end_cnt) begin
            wait_d = '0;
            if (cur_phase == PH_SENDW) begin
              phase_d = PH_ACK;
            end else if (cfg_i.resp_delay == '0) begin
              phase_d = PH_RECV;
              bit_d   = '0;
            end else begin
              phase_d = PH_DELAY;
            end
          end
        end
      end
      PH_ACK: begin
        if (wait_q >= cfg_i.ack_timeout) begin
          done    = 1'b1;
          status  = ST_TIMEOUT;
          phase_d = PH_IDLE;
        end else if (wait_q == '0) begin
          ack_ref_d  = item_i.out_line;
          wait_d     = WaitW'(1);
          poll_cnt_d = poll_one ? '0 : PollW'(1);
        end else if (poll_cnt_q == '0 && item_i.out_line != ack_ref_q) begin
          done    = 1'b1;
          status  = ST_OK;
          phase_d = PH_IDLE;
        end else begin
          wait_d     = wait_inc;
          poll_cnt_d = (poll_one || poll_inc == cfg_i.ack_poll) ? '0 : poll_inc;
        end
      end
      PH_DELAY: begin
        wait_d = wait_inc;
        if (wait_inc >= {{(WaitW-DelayW){1'b0}}, cfg_i.resp_delay}) begin
          phase_d = PH_RECV;
          bit_d   = '0;
          half_d  = 1'b0;
        end
      end
      PH_RECV: begin
        if (!cur_half) begin
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          resp_d = {resp_q[RespKeepW-2:0], item_i.out_line};
          bit_d  = bit_inc;
          if (bit_inc >= RespEnd) begin
            done    = 1'b1;
            phase_d = PH_IDLE;
            if (resp_d[15]) begin
              status = ST_RESP_ERR;
            end else begin
              status = ST_OK;
              hold_d = {resp_d[34:33], resp_d[32:23], resp_d[22:19]};
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_q      <= '0;
      half_q     <= 1'b0;
      wait_q     <= '0;
      poll_cnt_q <= '0;
      ack_ref_q  <= 1'b0;
      hold_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_q      <= bit_d;
      half_q     <= half_d;
      wait_q     <= wait_d;
      poll_cnt_q <= poll_cnt_d;
      ack_ref_q  <= ack_ref_d;
      hold_q     <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      frame_q <= frame_d;
      resp_q  <= resp_d;
    end
  end

  always_comb begin
    res_o.cal_line     = cal;
    res_o.busy         = (phase_d != PH_IDLE);
    res_o.done         = done;
    res_o.status       = status;
    res_o.agc_gain     = hold_d[HoldW-1 -: AgcW];
    res_o.led_current  = hold_d[RefW +: LedW];
    res_o.ref_readback = hold_d[RefW-1:0];
  end

endmodule

// ----- sv/manchester_sensor_frame_link_core.sv -----
// manchester_sensor_frame_link_core: top level, input register, result register and handshakes
// depends on msfl_pkg, msfl_cfg, msfl_engine
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  operation, ref_level, output_polarity, out_line
//   out      source     out_valid_o/out_stall_i cal_line, busy/done, status, readback fields
//   cfg      sink       cfg_we_i               cfg_index_i, cfg_data_i
//
// one beat per cycle sustained while out_stall_i is low; every input beat gives exactly one result beat
// path: input register, then the engine step into the result register
// the result register frees the input side, so a stalled result still lets one beat in
// reset clears control state and loads the register defaults; no clearing pass
module manchester_sensor_frame_link_core import msfl_pkg::*; #(
  parameter int unsigned PREAMBLE_BITS = PreambleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      operation_i,
  input  logic [RefW-1:0]     ref_level_i,
  input  logic                output_polarity_i,
  input  logic                out_line_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                cal_line_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [1:0]          status_o,
  output logic [AgcW-1:0]     agc_gain_o,
  output logic [LedW-1:0]     led_current_o,
  output logic [RefW-1:0]     ref_readback_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  msfl_cfg_t  cfg;
  msfl_item_t s1_item_q;
  msfl_res_t  step_res, out_res_q;
  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       out_ready, step, in_accept;

  msfl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  msfl_engine #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.op        <= msfl_op_e'(operation_i);
      s1_item_q.ref_level <= ref_level_i;
      s1_item_q.polarity  <= output_polarity_i;
      s1_item_q.out_line  <= out_line_i;
    end
    if (step) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cal_line_o     = out_res_q.cal_line;
  assign busy_res_o     = out_res_q.busy;
  assign done_res_o     = out_res_q.done;
  assign status_o       = out_res_q.status;
  assign agc_gain_o     = out_res_q.agc_gain;
  assign led_current_o  = out_res_q.led_current;
  assign ref_readback_o = out_res_q.ref_readback;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register can drain");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !busy_res_o)
    else $error("finishing beat still reports busy");

  a_status_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (status_o == ST_OK))
    else $error("nonzero status outside a finishing beat");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("engine step lost its result");
`endif

endmodule
